/* rtl/core/bitmap_frame_allocator_defines.svh */
// ----------------------------------------------------------------------------
// bitmap frame allocator assertion macros
// shared property shorthands, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types, widths and codes of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAMES    = 4096;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;

  localparam int OP_W    = 2;
  localparam int START_W = 12;
  localparam int CNT_W   = 13;
  localparam int END_W   = 13;
  localparam int RES_W   = 12;
  localparam int CUR_W   = 13;

  localparam int OFS_W   = $clog2(WORD_BITS);
  localparam int WORD_AW = $clog2(MAP_WORDS);
  localparam int AV_W    = OFS_W + 1;

  localparam logic [CUR_W-1:0] FRAMES_C  = CUR_W'(FRAMES);
  localparam logic [END_W-1:0] END_RESET = END_W'(4096);
  localparam logic [CUR_W-1:0] PTR_RESET = CUR_W'(1);

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t WORD_ONES = '1;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [START_W-1:0] start_frame;
    logic [CNT_W-1:0]   frame_count;
  } bfa_req_t;

  typedef struct packed {
    logic [RES_W-1:0] result_frame;
    logic             status;
  } bfa_rsp_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic a_eval;
    logic w_eval;
    logic publish;
  } bfa_cmd_t;

  typedef struct packed {
    logic a_succ;
    logic a_fail;
    logic a_same_word;
    logic w_last;
  } bfa_sts_t;

endpackage

/* rtl/core/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bfa_ctrl.sv */
// ----------------------------------------------------------------------------
// bfa_ctrl
// request sequencer: steps the datapath through scan, range update and result
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bfa_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bfa_cmd_t cmd_o,
  input  bfa_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARD,
    S_AEV,
    S_WRD,
    S_WEV,
    S_FIN
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  bfa_cmd_t cmd;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          priority if (in_data_i.frame_count == '0) begin
            state_d = S_FIN;
          end else if (in_data_i.opcode == OP_ALLOC) begin
            state_d = S_ARD;
          end else if (in_data_i.opcode == OP_FREE || in_data_i.opcode == OP_MARK) begin
            state_d = S_WRD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_ARD: begin
        cmd.rd  = 1'b1;
        state_d = S_AEV;
      end
      S_AEV: begin
        cmd.a_eval = 1'b1;
        priority if (sts_i.a_succ) begin
          state_d = S_WRD;
        end else if (sts_i.a_fail) begin
          state_d = S_FIN;
        end else if (sts_i.a_same_word) begin
          state_d = S_AEV;
        end else begin
          state_d = S_ARD;
        end
      end
      S_WRD: begin
        cmd.rd  = 1'b1;
        state_d = S_WEV;
      end
      S_WEV: begin
        cmd.w_eval = 1'b1;
        state_d    = sts_i.w_last ? S_FIN : S_WRD;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.publish = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* rtl/core/bfa_dp.sv */
// ----------------------------------------------------------------------------
// bfa_dp
// bitmap storage, search pointer, run scan and range update datapath
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_defines.svh"

module bfa_dp import bfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [END_W-1:0] cfg_data_i,
  input  bfa_req_t         in_data_i,
  input  bfa_cmd_t         cmd_i,
  output bfa_sts_t         sts_o,
  output bfa_rsp_t         out_data_o
);

  logic [END_W-1:0]   end_q;
  logic [CUR_W-1:0]   ptr_q;
  logic [MAP_WORDS-1:0] valid_q;
  logic               rd_valid_q;

  logic [CUR_W-1:0]   cur_q, run_q, cnt_q, rem_q;
  logic               set_q;
  logic [RES_W-1:0]   res_frame_q;
  logic               res_status_q;
  bfa_rsp_t           out_q;

  word_t              ram_rdata, wd, used, mask, wdata;
  logic [WORD_AW-1:0] word_idx;
  logic [CUR_W-1:0]   limit, lim_rem, need, avail_c, ku_c, hit_next, cur_w, rem_w;
  logic [OFS_W-1:0]   ofs, u;
  logic [AV_W-1:0]    avail, ku, take, hi_sh;
  logic               past, any, succ, fail, hit;

  assign word_idx = cur_q[OFS_W +: WORD_AW];
  assign ofs      = cur_q[OFS_W-1:0];
  assign wd       = rd_valid_q ? ram_rdata : '0;

  // run scan over one word
  assign limit   = (end_q < FRAMES_C) ? end_q : FRAMES_C;
  assign past    = (cur_q >= limit);
  assign lim_rem = past ? '0 : (limit - cur_q);
  assign need    = cnt_q - run_q;
  assign avail   = AV_W'(WORD_BITS) - AV_W'(ofs);
  assign avail_c = CUR_W'(avail);
  assign used    = wd & (WORD_ONES << ofs);

  always_comb begin
    any = 1'b0;
    u   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (used[i]) begin
        any = 1'b1;
        u   = OFS_W'(i);
      end
    end
  end

  assign ku       = AV_W'(u) - AV_W'(ofs);
  assign ku_c     = CUR_W'(ku);
  // at equal distance: run complete beats limit, limit beats a used frame
  assign succ     = (need <= avail_c) && (need <= lim_rem) && (!any || need <= ku_c);
  assign fail     = !succ && (lim_rem <= avail_c) && (!any || lim_rem <= ku_c);
  assign hit      = !succ && !fail && any;
  assign hit_next = cur_q + ku_c + CUR_W'(1);

  // range update over one word
  assign take  = (rem_q < avail_c) ? AV_W'(rem_q) : avail;
  assign hi_sh = AV_W'(ofs) + take;
  assign mask  = (WORD_ONES << ofs) & ~(WORD_ONES << hi_sh);
  assign wdata = set_q ? (wd | mask) : (wd & ~mask);
  assign cur_w = cur_q + CUR_W'(take);
  assign rem_w = rem_q - CUR_W'(take);

  assign sts_o.a_succ      = succ;
  assign sts_o.a_fail      = fail;
  assign sts_o.a_same_word = hit && (u != OFS_W'(WORD_BITS - 1));
  assign sts_o.w_last      = (rem_w == '0) || (cur_w >= FRAMES_C);

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.w_eval),
    .waddr_i (word_idx),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (word_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q      <= END_RESET;
      ptr_q      <= PTR_RESET;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        end_q <= cfg_data_i;
      end
      if (cmd_i.a_eval && hit) begin
        ptr_q <= hit_next;
      end
      if (cmd_i.rd) begin
        rd_valid_q <= valid_q[word_idx];
      end
      // a word never written reads as all free
      if (cmd_i.w_eval) begin
        valid_q[word_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      run_q        <= '0;
      cnt_q        <= in_data_i.frame_count;
      rem_q        <= in_data_i.frame_count;
      set_q        <= (in_data_i.opcode == OP_MARK);
      res_status_q <= 1'b0;
      if (in_data_i.opcode == OP_ALLOC) begin
        cur_q       <= ptr_q;
        res_frame_q <= ptr_q[RES_W-1:0];
      end else begin
        cur_q       <= CUR_W'(in_data_i.start_frame);
        res_frame_q <= '0;
      end
    end
    if (cmd_i.a_eval) begin
      priority if (succ) begin
        cur_q       <= ptr_q;
        rem_q       <= cnt_q;
        set_q       <= 1'b1;
        res_frame_q <= ptr_q[RES_W-1:0];
      end else if (fail) begin
        res_frame_q  <= '0;
        res_status_q <= 1'b1;
      end else if (hit) begin
        cur_q <= hit_next;
        run_q <= '0;
      end else begin
        cur_q <= cur_q + avail_c;
        run_q <= run_q + avail_c;
      end
    end
    if (cmd_i.w_eval) begin
      cur_q <= cur_w;
      rem_q <= rem_w;
    end
    if (cmd_i.publish) begin
      out_q.result_frame <= res_frame_q;
      out_q.status       <= res_status_q;
    end
  end

  assign out_data_o = out_q;

  `BFA_ASSERT_IMP(a_run_below_limit, cmd_i.a_eval && succ,
    ({1'b0, ptr_q} + {1'b0, cnt_q}) <= {1'b0, limit}, "allocated run crosses the limit")
  `BFA_ASSERT_IMP(a_write_in_map, cmd_i.w_eval, cur_q < FRAMES_C,
    "bitmap write beyond capacity")
  `BFA_ASSERT_NXT(a_same_word_kept, cmd_i.a_eval && sts_o.a_same_word,
    cur_q[OFS_W +: WORD_AW] == $past(cur_q[OFS_W +: WORD_AW]), "scan left the loaded word")
  `BFA_ASSERT_IMP(a_ptr_range, 1'b1, ptr_q <= FRAMES_C, "search pointer beyond capacity")

endmodule

/* rtl/core/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// next-fit bitmap allocator of physical frames: allocate run, free, mark
// ----------------------------------------------------------------------------
//   channel   dir  handshake                  beat
//   cfg       in   cfg_valid_i / cfg_ready_o  end_frame (13b)
//   in        in   in_valid_i  / in_ready_o   opcode, start_frame, frame_count
//   out       out  out_valid_o / out_ready_i  result_frame, status
//
// one request at a time; every bitmap word visited goes through a ram read state
// and an evaluate state, and an allocate spends one more evaluate state on each
// used frame it jumps inside a word.
// reset clears per-word valid flags at once; an unwritten word reads all free.
// a result waiting in the output register does not block the next request,
// only that request's hand-off.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [END_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bfa_req_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bfa_rsp_t         out_data_o
);

  bfa_cmd_t cmd;
  bfa_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bfa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/frame_alloc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_alloc_checker
// watches the config, request and result channels of the frame allocator,
// keeps its own bitmap, search pointer and end frame, and compares every
// result beat field by field with the oldest predicted reply
// ----------------------------------------------------------------------------
module frame_alloc_checker
  import bfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [END_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  bfa_req_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  bfa_rsp_t         out_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  bit               frame_map [FRAMES];
  int unsigned      scan_ptr;
  logic [END_W-1:0] end_frame_q;
  bfa_rsp_t         replies [$];
  int               mismatches = 0;
  int               backlog = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = backlog;

  // frames at or above capacity are dropped
  function automatic void write_run(input int unsigned first, input int unsigned len,
                                    input bit used);
    int unsigned f;
    for (f = first; f < first + len; f++) begin
      if (f < FRAMES) frame_map[f] = used;
    end
  endfunction

  function automatic bfa_rsp_t apply_request(input bfa_req_t req);
    bfa_rsp_t    rsp;
    int unsigned len;
    int unsigned limit;
    int unsigned i;
    bit          settled;
    rsp   = '0;
    len   = req.frame_count;
    limit = (end_frame_q < FRAMES) ? end_frame_q : FRAMES;
    case (req.opcode)
      OP_ALLOC: begin
        settled = 1'b0;
        while (!settled) begin
          for (i = 0; i < len; i++) begin
            if (scan_ptr + i >= limit || frame_map[scan_ptr + i]) break;
          end
          if (i == len) begin
            write_run(scan_ptr, len, 1'b1);
            rsp.result_frame = RES_W'(scan_ptr);
            settled = 1'b1;
          end else if (scan_ptr + i >= limit) begin
            // pointer keeps whatever it advanced during the search
            rsp.status = 1'b1;
            settled = 1'b1;
          end else begin
            // jump past the used frame that broke the run
            scan_ptr = (scan_ptr + i + 1) % (1 << CUR_W);
          end
        end
      end
      OP_FREE: write_run(req.start_frame, len, 1'b0);
      OP_MARK: write_run(req.start_frame, len, 1'b1);
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bfa_rsp_t want;
    if (!rst_ni) begin
      frame_map = '{default: 1'b0};
      scan_ptr = PTR_RESET;
      end_frame_q = END_RESET;
      replies.delete();
      backlog <= 0;
    end else begin
      // retire before predicting, so a stray beat never meets a fresh reply
      if (out_valid_i && out_ready_i) begin
        if (replies.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, frame %0d status %0d",
                   $time, out_data_i.result_frame, out_data_i.status);
          mismatches++;
        end else begin
          want = replies.pop_front();
          if (out_data_i.result_frame !== want.result_frame) begin
            $display("%0t: result_frame mismatch, expected %0d, actual %0d",
                     $time, want.result_frame, out_data_i.result_frame);
            mismatches++;
          end
          if (out_data_i.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data_i.status);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) end_frame_q = cfg_data_i;
      if (in_valid_i && in_ready_i) replies.push_back(apply_request(in_data_i));
      backlog <= replies.size();
    end
  end

endmodule

/* tb/tb_bitmap_frame_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator
// directed and random allocate, free, mark and unused-opcode requests over several
// end frame settings, with random gaps on both channels and one long result stall
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 40000;
  localparam int TAIL_CYCLES = 40;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [END_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  bfa_req_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  bfa_rsp_t         out_data_o;

  int fail_count;
  int pending;
  int stall_cycles = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit squeeze_req = 1'b0;

  always #1 clk_i = ~clk_i;

  bitmap_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  frame_alloc_checker alloc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
                 (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // result side: random gaps, plus one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      if (squeeze_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        squeeze_req = 1'b0;
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_request(input bfa_req_t req);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input int unsigned first,
                       input int unsigned len);
    bfa_req_t req;
    req.opcode      = op;
    req.start_frame = START_W'(first);
    req.frame_count = CNT_W'(len);
    send_request(req);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_end_frame(input logic [END_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly short runs; a rare long one that reaches the top count bit
  function automatic int unsigned random_length(input int unsigned short_max);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 0;
    if (pick < 75) return $urandom_range(1, short_max);
    if (pick < 97) return $urandom_range(short_max + 1, 64);
    if (pick < 99) return $urandom_range(65, 600);
    return $urandom_range(601, (1 << CNT_W) - 1);
  endfunction

  function automatic bfa_req_t random_request();
    bfa_req_t    req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    req.start_frame = START_W'($urandom);
    if (pick < 45) begin
      req.opcode      = OP_ALLOC;
      req.frame_count = CNT_W'(random_length(8));
    end else if (pick < 72) begin
      req.opcode      = OP_FREE;
      req.frame_count = CNT_W'(random_length(32));
    end else if (pick < 95) begin
      req.opcode      = OP_MARK;
      req.frame_count = CNT_W'(random_length(12));
    end else begin
      req.opcode      = OP_UNUSED;
      req.frame_count = CNT_W'($urandom);
    end
    return req;
  endfunction

  task automatic run_phase(input int unsigned end_value, input int unsigned items,
                           input bit squeeze);
    int unsigned k;
    wait_idle();
    write_end_frame(END_W'(end_value));
    for (k = 0; k < items; k++) begin
      if (k % 50 == 0) begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_gaps_on = ($urandom_range(0, 3) != 0);
      end
      // back-to-back requests against a stalled result side
      if (squeeze && k == items / 2) begin
        tx_gaps_on  = 1'b0;
        squeeze_req = 1'b1;
      end
      send_request(random_request());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset end frame, hand-checked sequence
    issue(OP_ALLOC, 0, 0);
    issue(OP_ALLOC, 4095, 1);
    issue(OP_ALLOC, 0, 3);
    issue(OP_MARK, 10, 2);
    issue(OP_ALLOC, 0, 8);
    issue(OP_UNUSED, 4095, 8191);
    issue(OP_MARK, 4095, 8191);
    issue(OP_FREE, 4090, 8191);
    issue(OP_MARK, 0, 0);
    issue(OP_FREE, 0, 0);
    issue(OP_ALLOC, 0, 8191);
    issue(OP_ALLOC, 0, 4096);
    issue(OP_MARK, 60, 10);
    issue(OP_ALLOC, 0, 64);
    issue(OP_FREE, 0, 4096);
    issue(OP_ALLOC, 0, 0);
    issue(OP_MARK, 4095, 1);
    issue(OP_FREE, 4095, 1);
    issue(OP_ALLOC, 0, 2);

    run_phase(0, 80, 1'b0);
    run_phase(200, 150, 1'b0);
    run_phase((1 << END_W) - 1, 400, 1'b1);
    run_phase(4095, 300, 1'b0);
    run_phase($urandom_range(0, (1 << END_W) - 1), 200, 1'b0);
    run_phase(FRAMES, 250, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* bitmap_frame_allocator.f */
+incdir+rtl/core
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dp.sv
rtl/core/bitmap_frame_allocator.sv
tb/frame_alloc_checker.sv
tb/tb_bitmap_frame_allocator.sv
